// ===== sv/homography_source_coordinate_defines.svh =====
// ----------------------------------------------------------------------------
// homography_source_coordinate_defines
// Assertion macros shared by the homography source coordinate RTL.
// ----------------------------------------------------------------------------
`ifndef HOMOGRAPHY_SOURCE_COORDINATE_DEFINES_SVH
`define HOMOGRAPHY_SOURCE_COORDINATE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off while rst_n is low
`define HSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("implication check failed");
// next-cycle implication
`define HSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("next-cycle check failed");
`else
`define HSC_ASSERT_IMP(label, ante, cons)
`define HSC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ===== sv/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc_pkg
// Types, widths and register indexes of the homography source coordinate unit.
// ----------------------------------------------------------------------------
`default_nettype none
package hsc_pkg;

  localparam int COEF_W = 32;   // Q16.16 coefficient
  localparam int CFG_W  = 64;
  localparam int IDX_W  = 3;
  localparam int CRD_W  = 12;   // destination coordinate
  localparam int PRD_W  = 45;   // coefficient times coordinate
  localparam int SUM_W  = 46;   // signed sum of three terms
  localparam int DW     = 45;   // magnitude of a sum
  localparam int QW     = 17;   // quotient bits resolved
  localparam int DIV_LAT = QW + 1;
  localparam int OUT_LAT = 3 + DIV_LAT + 1;

  localparam logic [IDX_W-1:0] REG_ROW0_A   = 3'd0;
  localparam logic [IDX_W-1:0] REG_ROW0B_1A = 3'd1;
  localparam logic [IDX_W-1:0] REG_ROW1_B   = 3'd2;
  localparam logic [IDX_W-1:0] REG_ROW2_A   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROW2_B   = 3'd4;
  localparam logic [IDX_W-1:0] REG_WIDTH    = 3'd5;
  localparam logic [IDX_W-1:0] REG_HEIGHT   = 3'd6;

  typedef struct packed {
    logic signed [COEF_W-1:0] h00, h01, h02;
    logic signed [COEF_W-1:0] h10, h11, h12;
    logic signed [COEF_W-1:0] h20, h21, h22;
  } coef_t;

  typedef struct packed {
    logic                    valid;
    logic signed [SUM_W-1:0] w;
    logic signed [SUM_W-1:0] nu;
    logic signed [SUM_W-1:0] nv;
  } mac_out_t;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic [DW-1:0] num;
    logic [DW-1:0] den;
  } div_in_t;

  typedef struct packed {
    logic          valid;
    logic          neg;
    logic          ovf;
    logic [QW-1:0] q;
  } div_out_t;

  // signed 16-bit result from quotient magnitude, sign and overflow
  function automatic logic signed [15:0] sat16(input div_out_t d);
    logic signed [15:0] r;
    r = '0;
    if (d.neg) begin
      if (d.ovf || d.q > 17'd32768) r = 16'sh8000;
      else r = 16'(-$signed({1'b0, d.q}));
    end else begin
      if (d.ovf || d.q > 17'd32767) r = 16'sh7fff;
      else r = 16'(d.q);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/homography_source_coordinate.sv =====
// ----------------------------------------------------------------------------
// homography_source_coordinate
// Inverse warp of a destination pixel through a 3x3 Q16.16 homography.
// ----------------------------------------------------------------------------
// A result strobes out once its start has passed the MAC, split, divider and output registers.
// Throughput: one coordinate per clock; set by the 17 single-bit divider
//   stages, each of which retires one quotient bit per cycle.
// Reset: synchronous, active low; clears all valid bits and loads the
//   identity map with a 1024 x 768 source image. busy is high in reset only.
// The receiver cannot stall, so the pipeline always advances.
`default_nettype none
`include "homography_source_coordinate_defines.svh"
module homography_source_coordinate import hsc_pkg::*; #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [CRD_W-1:0]   in_dst_x,
  input  wire logic [CRD_W-1:0]   in_dst_y,
  output logic                    out_valid,
  output logic signed [15:0]      out_src_x,
  output logic signed [15:0]      out_src_y,
  output logic                    out_inside_res,
  input  wire logic               cfg_we,
  input  wire logic [IDX_W-1:0]   cfg_idx,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam logic [COEF_W-1:0] ONE_Q     = COEF_W'(64'd1 << FRAC_BITS);
  localparam logic [15:0]       MAX_DIM_L = 16'(MAX_DIM);

  // Configuration registers
  coef_t       coef_r;
  logic [12:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '{h00: ONE_Q, h11: ONE_Q, h22: ONE_Q, default: '0};
      width_r  <= 13'd1024;
      height_r <= 13'd768;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_ROW0_A: begin
          coef_r.h00 <= cfg_wdata[31:0];
          coef_r.h01 <= cfg_wdata[63:32];
        end
        REG_ROW0B_1A: begin
          coef_r.h02 <= cfg_wdata[31:0];
          coef_r.h10 <= cfg_wdata[63:32];
        end
        REG_ROW1_B: begin
          coef_r.h11 <= cfg_wdata[31:0];
          coef_r.h12 <= cfg_wdata[63:32];
        end
        REG_ROW2_A: begin
          coef_r.h20 <= cfg_wdata[31:0];
          coef_r.h21 <= cfg_wdata[63:32];
        end
        REG_ROW2_B: coef_r.h22 <= cfg_wdata[31:0];
        REG_WIDTH:  width_r  <= cfg_wdata[12:0];
        REG_HEIGHT: height_r <= cfg_wdata[12:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Nothing is taken while in reset; otherwise every start is a transaction.
  assign busy = ~rst_n;

  // Stages 1-2: products, then the three sums
  mac_out_t mo;

  hsc_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .x        (in_dst_x),
    .y        (in_dst_y),
    .h        (coef_r),
    .mo       (mo)
  );

  // Stage 3: split into sign and magnitude, flag a zero divisor
  div_in_t        du_r, dv_r;
  logic           wz_s3_r;
  logic [DW-1:0]  mag_w_nxt, mag_u_nxt, mag_v_nxt;

  always_comb begin
    mag_w_nxt = mo.w[SUM_W-1]  ? DW'(-mo.w)  : mo.w[DW-1:0];
    mag_u_nxt = mo.nu[SUM_W-1] ? DW'(-mo.nu) : mo.nu[DW-1:0];
    mag_v_nxt = mo.nv[SUM_W-1] ? DW'(-mo.nv) : mo.nv[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      du_r.valid <= 1'b0;
      dv_r.valid <= 1'b0;
    end else begin
      du_r.valid <= mo.valid;
      dv_r.valid <= mo.valid;
    end
    du_r.neg <= mo.nu[SUM_W-1] ^ mo.w[SUM_W-1];
    dv_r.neg <= mo.nv[SUM_W-1] ^ mo.w[SUM_W-1];
    du_r.num <= mag_u_nxt;
    dv_r.num <= mag_v_nxt;
    du_r.den <= mag_w_nxt;
    dv_r.den <= mag_w_nxt;
    wz_s3_r  <= (mo.w == '0);
  end

  // Divider pipelines for u and v; carry the zero flag alongside
  div_out_t             dq_u, dq_v;
  logic [DIV_LAT-1:0]   wz_r;

  hsc_div u_div_u (.clk(clk), .rst_n(rst_n), .di(du_r), .dq(dq_u));
  hsc_div u_div_v (.clk(clk), .rst_n(rst_n), .di(dv_r), .dq(dq_v));

  always_ff @(posedge clk) begin
    wz_r <= {wz_r[DIV_LAT-2:0], wz_s3_r};
  end

  // Final stage: saturate, apply the inside test, register the result
  logic signed [15:0] u_nxt, v_nxt;
  logic [15:0]        lim_w, lim_h;
  logic               inside_nxt;
  logic               out_valid_r, inside_r;
  logic signed [15:0] src_x_r, src_y_r;

  always_comb begin
    lim_w = ({3'b0, width_r}  > MAX_DIM_L) ? MAX_DIM_L : {3'b0, width_r};
    lim_h = ({3'b0, height_r} > MAX_DIM_L) ? MAX_DIM_L : {3'b0, height_r};
    u_nxt = wz_r[DIV_LAT-1] ? 16'sd0 : sat16(dq_u);
    v_nxt = wz_r[DIV_LAT-1] ? 16'sd0 : sat16(dq_v);
    inside_nxt = !wz_r[DIV_LAT-1] &&
                 !u_nxt[15] && ({1'b0, u_nxt[14:0]} < lim_w) &&
                 !v_nxt[15] && ({1'b0, v_nxt[14:0]} < lim_h);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= dq_u.valid;
    src_x_r  <= u_nxt;
    src_y_r  <= v_nxt;
    inside_r <= inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_src_x      = src_x_r;
  assign out_src_y      = src_y_r;
  assign out_inside_res = inside_r;

  // Every transaction comes out after the fixed latency.
  `HSC_ASSERT_IMP(a_latency, start && !busy, ##OUT_LAT out_valid)
  // An inside point never has a negative coordinate.
  `HSC_ASSERT_IMP(a_inside_nonneg, out_valid && out_inside_res, !out_src_x[15] && !out_src_y[15])
  // A zero divisor yields a zero, outside result.
  `HSC_ASSERT_NXT(a_zero_div, dq_u.valid && wz_r[DIV_LAT-1], out_valid && !out_inside_res && out_src_x == 16'sd0 && out_src_y == 16'sd0)

endmodule
`default_nettype wire

// ===== sv/hsc_mac.sv =====
// ----------------------------------------------------------------------------
// hsc_mac
// Two-stage multiply and sum: w, nu and nv of one destination coordinate.
// ----------------------------------------------------------------------------
`default_nettype none
module hsc_mac import hsc_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic [CRD_W-1:0] x,
  input  wire logic [CRD_W-1:0] y,
  input  wire coef_t            h,
  output mac_out_t              mo
);

  logic signed [PRD_W-1:0] p_r [6];
  logic                    v1_r;
  mac_out_t                mo_r;
  logic signed [CRD_W:0]   xs, ys;

  assign xs = $signed({1'b0, x});
  assign ys = $signed({1'b0, y});

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= in_valid;
    p_r[0] <= h.h20 * xs;
    p_r[1] <= h.h21 * ys;
    p_r[2] <= h.h00 * xs;
    p_r[3] <= h.h01 * ys;
    p_r[4] <= h.h10 * xs;
    p_r[5] <= h.h11 * ys;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mo_r.valid <= 1'b0;
    else mo_r.valid <= v1_r;
    mo_r.w  <= SUM_W'(p_r[0]) + SUM_W'(p_r[1]) + SUM_W'(h.h22);
    mo_r.nu <= SUM_W'(p_r[2]) + SUM_W'(p_r[3]) + SUM_W'(h.h02);
    mo_r.nv <= SUM_W'(p_r[4]) + SUM_W'(p_r[5]) + SUM_W'(h.h12);
  end

  assign mo = mo_r;

endmodule
`default_nettype wire

// ===== sv/hsc_div.sv =====
// ----------------------------------------------------------------------------
// hsc_div
// Pipelined restoring divider: overflow stage, then one quotient bit a stage.
// ----------------------------------------------------------------------------
`default_nettype none
module hsc_div import hsc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  div_in_t   di,
  output div_out_t  dq
);

  logic          v_r   [0:QW];
  logic          neg_r [0:QW];
  logic          ovf_r [0:QW];
  logic [DW-1:0] rem_r [0:QW];
  logic [DW-1:0] den_r [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          ovf_nxt;

  // quotient needs more than QW bits: flag it and saturate later
  assign ovf_nxt = {{QW{1'b0}}, di.num} >= {di.den, {QW{1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else v_r[0] <= di.valid;
    neg_r[0] <= di.neg;
    ovf_r[0] <= ovf_nxt;
    rem_r[0] <= di.num;
    den_r[0] <= di.den;
    q_r[0]   <= '0;
  end

  for (genvar i = 0; i < QW; i++) begin : g_bit
    localparam int K = QW - 1 - i;
    logic [DW+QW-1:0] sh;
    logic             ge;
    logic [DW-1:0]    rem_nxt;
    logic [QW-1:0]    q_nxt;

    always_comb begin
      sh      = {{QW{1'b0}}, den_r[i]} << K;
      ge      = {{QW{1'b0}}, rem_r[i]} >= sh;
      rem_nxt = ge ? rem_r[i] - sh[DW-1:0] : rem_r[i];
      q_nxt   = {q_r[i][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_r[i];
      neg_r[i+1] <= neg_r[i];
      ovf_r[i+1] <= ovf_r[i];
      rem_r[i+1] <= rem_nxt;
      den_r[i+1] <= den_r[i];
      q_r[i+1]   <= q_nxt;
    end
  end

  assign dq.valid = v_r[QW];
  assign dq.neg   = neg_r[QW];
  assign dq.ovf   = ovf_r[QW];
  assign dq.q     = q_r[QW];

endmodule
`default_nettype wire

// ===== bench/hsc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hsc_checker
// Watches the command, result and register ports of the homography source
// coordinate unit, predicts each result from a private copy of the registers
// and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
`default_nettype none
module hsc_checker import hsc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire logic [CRD_W-1:0]  in_dst_x,
  input  wire logic [CRD_W-1:0]  in_dst_y,
  input  wire logic              out_valid,
  input  wire logic signed [15:0] out_src_x,
  input  wire logic signed [15:0] out_src_y,
  input  wire logic              out_inside_res,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  output int                     fail_count,
  output int                     pending
);

  localparam int DIM_CAP = 4096;

  typedef struct packed {
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               in_img;
  } src_point_t;

  logic [63:0] row0_a, row0b_1a, row1_b, row2_a;
  logic [31:0] row2_b;
  logic [12:0] width_px, height_px;
  src_point_t  src_points_q[$];

  function automatic longint half_coef(input logic [63:0] r, input bit upper);
    return upper ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  function automatic longint sat16(input longint q);
    if (q > 32767) return 32767;
    if (q < -32768) return -32768;
    return q;
  endfunction

  function automatic src_point_t project_point(input logic [CRD_W-1:0] px,
                                               input logic [CRD_W-1:0] py);
    src_point_t p;
    longint x, y, den, num_u, num_v, u, v, wl, hl;
    x = longint'(px);
    y = longint'(py);
    den   = half_coef(row2_a, 0) * x + half_coef(row2_a, 1) * y + half_coef({32'd0, row2_b}, 0);
    num_u = half_coef(row0_a, 0) * x + half_coef(row0_a, 1) * y + half_coef(row0b_1a, 0);
    num_v = half_coef(row0b_1a, 1) * x + half_coef(row1_b, 0) * y + half_coef(row1_b, 1);
    wl = (width_px > DIM_CAP) ? DIM_CAP : longint'(width_px);
    hl = (height_px > DIM_CAP) ? DIM_CAP : longint'(height_px);
    p = '0;
    if (den != 0) begin
      u = sat16(num_u / den);   // integer division truncates toward zero
      v = sat16(num_v / den);
      p.sx = 16'(u);
      p.sy = 16'(v);
      p.in_img = (u >= 0) && (u < wl) && (v >= 0) && (v < hl);
    end
    return p;
  endfunction

  assign pending = src_points_q.size();

  always @(posedge clk) begin
    src_point_t e;
    if (!rst_n) begin
      row0_a    <= 64'd65536;
      row0b_1a  <= 64'd0;
      row1_b    <= 64'd65536;
      row2_a    <= 64'd0;
      row2_b    <= 32'd65536;
      width_px  <= 13'd1024;
      height_px <= 13'd768;
      src_points_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ROW0_A:   row0_a    <= cfg_wdata;
          REG_ROW0B_1A: row0b_1a  <= cfg_wdata;
          REG_ROW1_B:   row1_b    <= cfg_wdata;
          REG_ROW2_A:   row2_a    <= cfg_wdata;
          REG_ROW2_B:   row2_b    <= cfg_wdata[31:0];
          REG_WIDTH:    width_px  <= cfg_wdata[12:0];
          REG_HEIGHT:   height_px <= cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (src_points_q.size() == 0) begin
          $error("result with no transaction outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = src_points_q.pop_front();
          if (out_src_x !== e.sx || out_src_y !== e.sy || out_inside_res !== e.in_img)
            fail_count <= fail_count + 1;
          if (out_src_x !== e.sx)
            $error("src_x expected %0d got %0d", e.sx, out_src_x);
          if (out_src_y !== e.sy)
            $error("src_y expected %0d got %0d", e.sy, out_src_y);
          if (out_inside_res !== e.in_img)
            $error("inside_res expected %0b got %0b", e.in_img, out_inside_res);
        end
      end
      if (start && !busy) src_points_q.push_back(project_point(in_dst_x, in_dst_y));
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the homography source coordinate unit: directed
// corner points and register settings, then random configuration phases
// with random destination points, all checked by hsc_checker.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import hsc_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;   // no register here
  localparam int CYCLE_LIMIT = 300000;
  localparam int ONE = 65536;                        // 1.0 in Q16.16

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [CRD_W-1:0]   in_dst_x = '0;
  logic [CRD_W-1:0]   in_dst_y = '0;
  logic               out_valid;
  logic signed [15:0] out_src_x, out_src_y;
  logic               out_inside_res;
  logic               cfg_we = 1'b0;
  logic [IDX_W-1:0]   cfg_idx = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  int                 fail_count, pending, cycle_cnt = 0;
  bit                 gaps_on = 1'b1;

  always #5 clk = ~clk;

  homography_source_coordinate u_top (
    .clk, .rst_n, .start, .busy, .in_dst_x, .in_dst_y,
    .out_valid, .out_src_x, .out_src_y, .out_inside_res,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  hsc_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_dst_x, .in_dst_y,
    .out_valid, .out_src_x, .out_src_y, .out_inside_res,
    .cfg_we, .cfg_idx, .cfg_wdata, .fail_count, .pending
  );

  // hard stop in case the unit hangs
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[homography_source_coordinate] ERROR");
      $finish;
    end
  end

  // Present one coordinate and hold it until a transaction happens. Start
  // stays high into the next item unless an idle cycle is drawn.
  task automatic send_point(input int x, input int y);
    @(negedge clk);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 15) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start    <= 1'b1;
    in_dst_x <= CRD_W'(x);
    in_dst_y <= CRD_W'(y);
    do @(posedge clk); while (busy);
  endtask

  // Drop start and hold until every outstanding result is back.
  task automatic drain;
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic write_all(input int h00, input int h01, input int h02,
                           input int h10, input int h11, input int h12,
                           input int h20, input int h21, input int h22,
                           input int w, input int h);
    write_reg(REG_ROW0_A,   {32'(h01), 32'(h00)});
    write_reg(REG_ROW0B_1A, {32'(h10), 32'(h02)});
    write_reg(REG_ROW1_B,   {32'(h12), 32'(h11)});
    write_reg(REG_ROW2_A,   {32'(h21), 32'(h20)});
    write_reg(REG_ROW2_B,   {32'd0, 32'(h22)});
    write_reg(REG_WIDTH,    64'(w));
    write_reg(REG_HEIGHT,   64'(h));
  endtask

  function automatic int srand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int rand_coord;
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 4095;
      default: return int'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic int rand_dim;
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 8191));   // zero and oversized too
      1: return 4096;
      default: return int'($urandom_range(1, 4096));
    endcase
  endfunction

  initial begin
    int mode;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity map out of reset: corners and the image edge
    send_point(0, 0);
    send_point(4095, 4095);
    send_point(1023, 767);
    send_point(1024, 0);
    send_point(0, 768);
    drain();

    // mirror: negative coordinates, and a write to an unused index
    write_all(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE, 4096, 4096);
    write_reg(REG_UNUSED, {64{1'b1}});
    send_point(0, 0);
    send_point(4095, 1);
    send_point(4095, 4095);
    drain();

    // divisor zero everywhere, then zero only at column 5
    write_all(ONE, 0, 0, 0, ONE, 0, 0, 0, 0, 8191, 0);
    send_point(7, 9);
    drain();
    write_all(ONE, ONE, 3, 0, ONE, 0, 1, 0, -5, 8191, 4096);
    send_point(5, 100);
    send_point(4, 100);
    send_point(6, 4095);
    drain();

    // extreme coefficients: saturation both ways, and a tiny divisor
    write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
              32'h80000000, 0, 0, 1, 1, 1);
    send_point(4095, 4095);
    send_point(0, 0);
    send_point(1, 0);
    drain();
    write_all(32'h80000000, 32'h7fffffff, 0, 1, 1, 0, 32'h7fffffff, 32'h80000000,
              32'h80000000, 4096, 1);
    send_point(4095, 0);
    send_point(0, 4095);
    send_point(4095, 4095);
    send_point(2048, 2048);
    drain();

    // random phases, each with a fresh register setting
    for (int ph = 0; ph < 10; ph++) begin
      mode = $urandom_range(0, 9);
      gaps_on = (ph != 4);   // one phase runs back to back
      if (mode < 5)          // near-affine with mild perspective
        write_all(ONE + srand(ONE/2), srand(ONE/2), srand(ONE*2000),
                  srand(ONE/2), ONE + srand(ONE/2), srand(ONE*2000),
                  srand(32), srand(32), ONE + srand(ONE/4), rand_dim(), rand_dim());
      else if (mode < 8)     // stronger perspective, divisor crosses zero
        write_all(srand(ONE*4), srand(ONE*4), srand(ONE*4000),
                  srand(ONE*4), srand(ONE*4), srand(ONE*4000),
                  srand(64), srand(64), srand(ONE*4), rand_dim(), rand_dim());
      else                   // fully random registers
        write_all(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                  int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                  int'($urandom), rand_dim(), rand_dim());
      repeat (65) send_point(rand_coord(), rand_coord());
      drain();
    end

    repeat (30) @(posedge clk);
    if (fail_count == 0)
      $display("[homography_source_coordinate] OK");
    else
      $display("[homography_source_coordinate] ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/hsc_pkg.sv
sv/hsc_mac.sv
sv/hsc_div.sv
sv/homography_source_coordinate.sv
bench/hsc_checker.sv
bench/tb_top.sv
